// ----- src/v4r_pkg.sv -----
// Shared widths, types and pipeline depth for the 4-component reflection unit.
// Used by every module of the block; depends on nothing.
`default_nettype none

package v4r_pkg;

    localparam int LANES = 4;
    localparam int DW = 32;
    localparam int PW = 64;
    localparam int DOTW = 66;
    localparam int MAGW = 65;
    localparam int NUMW = 97;
    localparam int QW = 34;
    localparam int REMW = 65;
    localparam int CW = QW + 1;
    localparam int RW = CW + 1;
    localparam int LANE_STAGES = QW + 4;
    localparam int PIPE_DEPTH = LANE_STAGES + 3;

    typedef logic signed [DW-1:0] word_t;
    typedef logic signed [PW-1:0] sprod_t;
    typedef logic [PW-1:0] uprod_t;

    typedef struct packed {
        logic [MAGW-1:0] mag;
        logic [MAGW-1:0] dnn;
        logic            neg;
        logic            zero;
    } dot_t;

    typedef struct packed {
        word_t           v;
        logic            nneg;
        logic            neg;
        logic            zero;
        logic [MAGW-1:0] d;
    } side_t;

endpackage

`default_nettype wire

// ----- src/vec4_reflect_unit_core.sv -----
// Top level of the 4-component reflection unit: r = v - 2*dot(v,n)*n/dot(n,n).
// Instantiates v4r_lane_mul, v4r_merge and v4r_lane_div; depends on v4r_pkg.
//
//   channel  direction  handshake             payload
//   in       to block   in_valid / in_ready   v_x..v_w, n_x..n_w
//   out      from block out_valid / out_ready r_x..r_w, zero_normal, saturated
//
// One transaction per cycle while the output is not stalled; results leave in the order of their inputs.
// Most of the pipeline depth comes from the 34-step pipelined divider in each lane.
// Reset clears only the valid bits of the pipeline.
// When out_valid is high and out_ready low, the whole pipeline holds and in_ready drops.
`default_nettype none

module vec4_reflect_unit_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire v4r_pkg::word_t v_x,
    input  wire v4r_pkg::word_t v_y,
    input  wire v4r_pkg::word_t v_z,
    input  wire v4r_pkg::word_t v_w,
    input  wire v4r_pkg::word_t n_x,
    input  wire v4r_pkg::word_t n_y,
    input  wire v4r_pkg::word_t n_z,
    input  wire v4r_pkg::word_t n_w,
    output logic                out_valid,
    input  wire logic           out_ready,
    output v4r_pkg::word_t      r_x,
    output v4r_pkg::word_t      r_y,
    output v4r_pkg::word_t      r_z,
    output v4r_pkg::word_t      r_w,
    output logic                zero_normal,
    output logic                saturated
);
    import v4r_pkg::*;

    logic en;
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    word_t v_arr [LANES];
    word_t n_arr [LANES];
    sprod_t prod_vn [LANES];
    uprod_t prod_nn [LANES];
    word_t v_d [LANES];
    logic [DW-1:0] nmag_d [LANES];
    logic nneg_d [LANES];
    dot_t dot;
    word_t r_arr [LANES];
    logic sat_arr [LANES];
    logic zero_arr [LANES];

    assign v_arr = '{v_x, v_y, v_z, v_w};
    assign n_arr = '{n_x, n_y, n_z, n_w};

    assign out_valid = valid_reg[PIPE_DEPTH-1];
    assign en = !out_valid || out_ready;
    assign in_ready = en;
    assign valid_next = {valid_reg[PIPE_DEPTH-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    for (genvar i = 0; i < LANES; i++)
    begin : g_mul
        v4r_lane_mul u_mul (
            .clk     (clk),
            .en      (en),
            .v       (v_arr[i]),
            .n       (n_arr[i]),
            .prod_vn (prod_vn[i]),
            .prod_nn (prod_nn[i]),
            .v_d     (v_d[i]),
            .nmag_d  (nmag_d[i]),
            .nneg_d  (nneg_d[i])
        );
    end

    v4r_merge u_merge (
        .clk     (clk),
        .en      (en),
        .prod_vn (prod_vn),
        .prod_nn (prod_nn),
        .dot     (dot)
    );

    for (genvar i = 0; i < LANES; i++)
    begin : g_div
        v4r_lane_div u_div (
            .clk  (clk),
            .en   (en),
            .dot  (dot),
            .v    (v_d[i]),
            .nmag (nmag_d[i]),
            .nneg (nneg_d[i]),
            .r    (r_arr[i]),
            .sat  (sat_arr[i]),
            .zero (zero_arr[i])
        );
    end

    assign r_x = r_arr[0];
    assign r_y = r_arr[1];
    assign r_z = r_arr[2];
    assign r_w = r_arr[3];
    assign zero_normal = zero_arr[0] & zero_arr[1] & zero_arr[2] & zero_arr[3];
    assign saturated = sat_arr[0] | sat_arr[1] | sat_arr[2] | sat_arr[3];

endmodule

`default_nettype wire

// ----- src/v4r_lane_mul.sv -----
// One lane of products: v_i*n_i and n_i*n_i, plus the lane's operands delayed
// to line up with the merged dot products. Depends on v4r_pkg.
`default_nettype none

module v4r_lane_mul (
    input  wire logic            clk,
    input  wire logic            en,
    input  wire v4r_pkg::word_t  v,
    input  wire v4r_pkg::word_t  n,
    output v4r_pkg::sprod_t      prod_vn,
    output v4r_pkg::uprod_t      prod_nn,
    output v4r_pkg::word_t       v_d,
    output logic [v4r_pkg::DW-1:0] nmag_d,
    output logic                 nneg_d
);
    import v4r_pkg::*;

    sprod_t pvn_reg;
    sprod_t pvn_next;
    sprod_t pnn_next;
    uprod_t pnn_reg;
    word_t v_reg [3];
    logic [DW-1:0] nmag_reg [3];
    logic nneg_reg [3];
    logic [DW-1:0] nmag_next;

    assign pvn_next = v * n;
    assign pnn_next = n * n;
    assign nmag_next = n[DW-1] ? (~n + 1'b1) : n;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pvn_reg <= pvn_next;
            pnn_reg <= $unsigned(pnn_next);
            v_reg[0] <= v;
            nmag_reg[0] <= nmag_next;
            nneg_reg[0] <= n[DW-1];
            for (int i = 1; i < 3; i++)
            begin
                v_reg[i] <= v_reg[i-1];
                nmag_reg[i] <= nmag_reg[i-1];
                nneg_reg[i] <= nneg_reg[i-1];
            end
        end
    end

    assign prod_vn = pvn_reg;
    assign prod_nn = pnn_reg;
    assign v_d = v_reg[2];
    assign nmag_d = nmag_reg[2];
    assign nneg_d = nneg_reg[2];

endmodule

`default_nettype wire

// ----- src/v4r_merge.sv -----
// Merging stage: sums the lane products into dot(v,n) and dot(n,n), then
// splits dot(v,n) into sign and magnitude. Depends on v4r_pkg.
`default_nettype none

module v4r_merge (
    input  wire logic            clk,
    input  wire logic            en,
    input  wire v4r_pkg::sprod_t prod_vn [v4r_pkg::LANES],
    input  wire v4r_pkg::uprod_t prod_nn [v4r_pkg::LANES],
    output v4r_pkg::dot_t        dot
);
    import v4r_pkg::*;

    logic signed [DOTW-1:0] dvn_reg;
    logic signed [DOTW-1:0] dvn_next;
    logic [MAGW-1:0] dnn_reg;
    logic [MAGW-1:0] dnn_next;
    logic [DOTW-1:0] dvn_abs;
    dot_t dot_reg;
    dot_t dot_next;

    always_comb
    begin
        dvn_next = '0;
        dnn_next = '0;
        for (int i = 0; i < LANES; i++)
        begin
            dvn_next = dvn_next + DOTW'(prod_vn[i]);
            dnn_next = dnn_next + MAGW'(prod_nn[i]);
        end
    end

    always_comb
    begin
        dvn_abs = dvn_reg[DOTW-1] ? (~dvn_reg + 1'b1) : dvn_reg;
        dot_next.mag = dvn_abs[MAGW-1:0];
        dot_next.dnn = dnn_reg;
        dot_next.neg = dvn_reg[DOTW-1];
        dot_next.zero = (dnn_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dvn_reg <= dvn_next;
            dnn_reg <= dnn_next;
            dot_reg <= dot_next;
        end
    end

    assign dot = dot_reg;

endmodule

`default_nettype wire

// ----- src/v4r_lane_div.sv -----
// One lane of the correction: 2*|dot(v,n)|*|n_i| in partial products, a pipelined
// restoring divide by dot(n,n), rounding, subtraction and clamping. Depends on v4r_pkg.
`default_nettype none

module v4r_lane_div (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire v4r_pkg::dot_t     dot,
    input  wire v4r_pkg::word_t    v,
    input  wire logic [v4r_pkg::DW-1:0] nmag,
    input  wire logic              nneg,
    output v4r_pkg::word_t         r,
    output logic                   sat,
    output logic                   zero
);
    import v4r_pkg::*;

    side_t side_in;
    side_t side_reg [QW+3];
    logic [PW-1:0] pp_lo_reg;
    logic [PW-1:0] pp_mid_reg;
    logic [DW-1:0] pp_top_reg;
    logic [NUMW-1:0] num_next;
    logic [NUMW-1:0] num_reg;
    logic [REMW-1:0] rem_reg [QW];
    logic [QW-1:0] quo_reg [QW];
    logic [QW-1:0] low_reg [QW];
    logic rnd;
    logic [CW-1:0] cmag;
    logic signed [RW-1:0] corr_next;
    logic signed [RW-1:0] corr_reg;
    logic signed [RW-1:0] diff;
    word_t r_next;
    word_t r_reg;
    logic sat_next;
    logic sat_reg;
    logic zero_reg;

    assign side_in = '{v: v, nneg: nneg, neg: dot.neg, zero: dot.zero, d: dot.dnn};

    always_comb
    begin
        num_next = NUMW'(pp_lo_reg) + (NUMW'(pp_mid_reg) << 32) + (NUMW'(pp_top_reg) << 64);
        num_next = num_next << 1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < QW + 3; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            pp_lo_reg <= PW'(dot.mag[31:0]) * PW'(nmag);
            pp_mid_reg <= PW'(dot.mag[63:32]) * PW'(nmag);
            pp_top_reg <= dot.mag[MAGW-1] ? nmag : '0;
            num_reg <= num_next;
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        logic [REMW-1:0] rem_in;
        logic [QW-1:0] quo_in;
        logic [QW-1:0] low_in;
        logic [REMW:0] trial;
        logic [REMW:0] dext;
        logic take;

        if (k == 0)
        begin : g_first
            assign rem_in = REMW'(num_reg[NUMW-1:QW]);
            assign quo_in = '0;
            assign low_in = num_reg[QW-1:0];
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign low_in = low_reg[k-1];
        end

        assign trial = {rem_in, low_in[QW-1]};
        assign dext = (REMW+1)'(side_reg[1+k].d);
        assign take = (trial >= dext);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= take ? REMW'(trial - dext) : REMW'(trial);
                quo_reg[k] <= {quo_in[QW-2:0], take};
                low_reg[k] <= low_in << 1;
            end
        end
    end

    always_comb
    begin
        rnd = ({rem_reg[QW-1], 1'b0} >= (REMW+1)'(side_reg[QW+1].d));
        cmag = CW'(quo_reg[QW-1]) + CW'(rnd);
        corr_next = (side_reg[QW+1].neg ^ side_reg[QW+1].nneg) ?
                    -$signed(RW'(cmag)) : $signed(RW'(cmag));
    end

    always_comb
    begin
        diff = RW'(side_reg[QW+2].v) - corr_reg;
        r_next = diff[DW-1:0];
        sat_next = 1'b0;
        if (side_reg[QW+2].zero)
        begin
            r_next = side_reg[QW+2].v;
        end
        else if (!diff[RW-1] && (|diff[RW-2:DW-1]))
        begin
            r_next = {1'b0, {(DW-1){1'b1}}};
            sat_next = 1'b1;
        end
        else if (diff[RW-1] && !(&diff[RW-2:DW-1]))
        begin
            r_next = {1'b1, {(DW-1){1'b0}}};
            sat_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            corr_reg <= corr_next;
            r_reg <= r_next;
            sat_reg <= sat_next;
            zero_reg <= side_reg[QW+2].zero;
        end
    end

    assign r = r_reg;
    assign sat = sat_reg;
    assign zero = zero_reg;

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for vec4_reflect_unit_core: random and directed vector/normal pairs
// are driven through a bursty sender, results are checked against an exact reflection model.
// Depends on v4r_pkg and vec4_reflect_unit_core.
`timescale 1ns / 1ps

module testbench;

    import v4r_pkg::*;

    typedef struct {
        logic signed [31:0] v [4];
        logic signed [31:0] n [4];
    } vecpair_t;

    typedef struct {
        logic signed [31:0] r [4];
        logic               zn;
        logic               sat;
    } reflection_t;

    localparam int LATENCY = PIPE_DEPTH;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    word_t v_x, v_y, v_z, v_w, n_x, n_y, n_z, n_w;
    logic out_valid;
    logic out_ready;
    word_t r_x, r_y, r_z, r_w;
    logic zero_normal;
    logic saturated;

    vecpair_t    pending_pairs[$];
    reflection_t expected_reflections[$];
    int          error_count;
    longint      cycle_count;
    bit          stimulus_done;
    bit          sender_hold;
    int          burst_left;
    int          gap_left;
    int          stall_long;
    bit          long_stall_req;

    vec4_reflect_unit_core uut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .v_x(v_x), .v_y(v_y), .v_z(v_z), .v_w(v_w),
        .n_x(n_x), .n_y(n_y), .n_z(n_z), .n_w(n_w),
        .out_valid(out_valid), .out_ready(out_ready),
        .r_x(r_x), .r_y(r_y), .r_z(r_z), .r_w(r_w),
        .zero_normal(zero_normal), .saturated(saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic reflection_t reflect_about_normal(vecpair_t p);
        reflection_t      res;
        logic signed [127:0] dvn;
        logic [127:0]     dnn;
        logic [127:0]     mag;
        logic [127:0]     num;
        logic [127:0]     quo;
        logic [127:0]     rem;
        logic [63:0]      nmag;
        logic signed [127:0] corr;
        logic signed [127:0] rv;
        logic             neg;
        dvn = 0;
        dnn = 0;
        res.sat = 1'b0;
        res.zn = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            dvn += 128'(signed'(p.v[i])) * 128'(signed'(p.n[i]));
            dnn += 128'(signed'(p.n[i])) * 128'(signed'(p.n[i]));
        end
        if (dnn == 0)
        begin
            res.r = p.v;
            res.zn = 1'b1;
            return res;
        end
        neg = dvn[127];
        mag = neg ? -dvn : dvn;
        for (int i = 0; i < 4; i++)
        begin
            nmag = p.n[i][31] ? 64'(-64'(signed'(p.n[i]))) : 64'(p.n[i]);
            num = (mag * 128'(nmag)) << 1;
            quo = num / dnn;
            rem = num % dnn;
            if ((rem << 1) >= dnn)
                quo = quo + 1;
            corr = (neg != p.n[i][31]) ? -signed'(quo) : signed'(quo);
            rv = 128'(signed'(p.v[i])) - corr;
            if (rv > 128'sd2147483647)
            begin
                res.r[i] = 32'h7FFFFFFF;
                res.sat = 1'b1;
            end
            else if (rv < -128'sd2147483648)
            begin
                res.r[i] = 32'h80000000;
                res.sat = 1'b1;
            end
            else
                res.r[i] = rv[31:0];
        end
        return res;
    endfunction

    function automatic logic [31:0] random_component();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'(signed'($urandom_range(0, 131072)) - 65536);
            2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            3: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            4: return 32'h0;
            default: return 32'($urandom()) >>> $urandom_range(0, 31);
        endcase
    endfunction

    task automatic queue_pair(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d,
                              logic [31:0] e, logic [31:0] f, logic [31:0] g, logic [31:0] h);
        vecpair_t p;
        p.v = '{a, b, c, d};
        p.n = '{e, f, g, h};
        pending_pairs.push_back(p);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("Mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        error_count++;
    endtask

    initial
    begin
        vecpair_t p;
        error_count = 0;
        stimulus_done = 1'b0;
        sender_hold = 1'b0;
        long_stall_req = 1'b0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        queue_pair(32'h00010000, 32'h00020000, 0, 0, 32'h00010000, 0, 0, 0);
        queue_pair(32'h12345678, 32'h87654321, 1, 2, 0, 0, 0, 0);
        queue_pair(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 0);
        queue_pair(32'h7FFFFFFF, 0, 0, 0, 32'h00000001, 0, 0, 0);
        queue_pair(32'h80000000, 0, 0, 0, 32'hFFFFFFFF, 0, 0, 0);
        queue_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        queue_pair(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                   32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        queue_pair(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                   32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        // Rounding ties: in the first three pairs below the correction ends in exactly half a unit.
        queue_pair(1, 0, 0, 0, 1, 1, 1, 1);
        queue_pair(32'hFFFFFFFF, 0, 0, 0, 1, 1, 1, 1);
        queue_pair(3, 0, 0, 0, 1, 32'hFFFFFFFF, 1, 1);
        queue_pair(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                   32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        queue_pair(5, 7, 32'hFFFFFFF0, 9, 32'h00030000, 32'hFFFD0000, 32'h00010000, 2);
        queue_pair(32'h40000000, 32'hC0000000, 32'h40000000, 32'hC0000000,
                   32'h00000001, 32'h7FFFFFFF, 32'h00000003, 32'h80000001);

        for (int k = 0; k < 1000; k++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                p.v[i] = random_component();
                p.n[i] = ($urandom_range(0, 19) == 0) ? 32'h0 : random_component();
            end
            pending_pairs.push_back(p);
            if (k == 300)
            begin
                long_stall_req = 1'b1;
                wait (pending_pairs.size() == 0);
                long_stall_req = 1'b0;
            end
            if (k == 600)
            begin
                wait (pending_pairs.size() == 0 && !in_valid);
                sender_hold = 1'b1;
                wait (expected_reflections.size() == 0);
                sender_hold = 1'b0;
            end
        end
        stimulus_done = 1'b1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            {v_x, v_y, v_z, v_w, n_x, n_y, n_z, n_w} <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_reflections.push_back(reflect_about_normal(pending_pairs.pop_front()));
            if (in_valid && !in_ready)
                ;
            else if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_pairs.size() > 0 && !sender_hold)
            begin
                in_valid <= 1'b1;
                v_x <= pending_pairs[0].v[0];
                v_y <= pending_pairs[0].v[1];
                v_z <= pending_pairs[0].v[2];
                v_w <= pending_pairs[0].v[3];
                n_x <= pending_pairs[0].n[0];
                n_y <= pending_pairs[0].n[1];
                n_z <= pending_pairs[0].n[2];
                n_w <= pending_pairs[0].n[3];
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 40);
                    gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_long <= 0;
        end
        else if (long_stall_req && stall_long == 0)
        begin
            stall_long <= 150;
            out_ready <= 1'b0;
        end
        else if (stall_long > 1)
        begin
            stall_long <= stall_long - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            if (stall_long == 1 && !long_stall_req)
                stall_long <= 0;
            else if (stall_long == 1)
                stall_long <= 1;
            case ((cycle_count / 64) % 4)
                0: out_ready <= 1'b1;
                1: out_ready <= $urandom_range(0, 1);
                2: out_ready <= $urandom_range(0, 7) != 0;
                default: out_ready <= (cycle_count % 5) != 0;
            endcase
        end
    end

    always @(posedge clk)
    begin
        reflection_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_reflections.size() == 0)
            begin
                $display("Unexpected result at cycle %0d", cycle_count);
                error_count++;
            end
            else
            begin
                want = expected_reflections.pop_front();
                if (r_x !== want.r[0]) report_mismatch("r_x", r_x, want.r[0]);
                if (r_y !== want.r[1]) report_mismatch("r_y", r_y, want.r[1]);
                if (r_z !== want.r[2]) report_mismatch("r_z", r_z, want.r[2]);
                if (r_w !== want.r[3]) report_mismatch("r_w", r_w, want.r[3]);
                if (zero_normal !== want.zn)
                    report_mismatch("zero_normal", 32'(zero_normal), 32'(want.zn));
                if (saturated !== want.sat)
                    report_mismatch("saturated", 32'(saturated), 32'(want.sat));
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles", cycle_count);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        wait (stimulus_done && pending_pairs.size() == 0 && !in_valid);
        wait (expected_reflections.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (error_count == 0 && expected_reflections.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/v4r_pkg.sv
src/v4r_lane_mul.sv
src/v4r_merge.sv
src/v4r_lane_div.sv
src/vec4_reflect_unit_core.sv
verif/testbench.sv
